[design/asla_pkg.sv]
package asla_pkg;

  localparam logic [7:0] ByteEsc     = 8'h1B;
  localparam logic [7:0] ByteCsiOpen = 8'h5B;
  localparam logic [7:0] ByteFinalLo = 8'h40;
  localparam logic [7:0] ByteFinalHi = 8'h7E;
  localparam logic [7:0] ByteCtrlTop = 8'h20;
  localparam logic [7:0] ByteTab     = 8'h09;
  localparam logic [7:0] ByteNewline = 8'h0A;

  localparam logic [31:0] SeqStart = 32'd1;

  // Escape decoder state
  typedef enum logic [2:0] {
    PH_PLAIN = 3'b001,
    PH_ESC   = 3'b010,
    PH_CSI   = 3'b100
  } phase_t;

  // Byte class handed from the escape filter to the row builder
  typedef struct packed {
    logic keep;
    logic newline;
  } byte_class_t;

  typedef struct packed {
    logic        has_char;
    logic [7:0]  char_value;
    logic [7:0]  column;
    logic [31:0] row_seq;
    logic        row_end;
  } result_t;

endpackage

[design/asla_filter.sv]
module asla_filter
  import asla_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        clear,
  input  logic [7:0]  byte_in,
  output byte_class_t cls
);

  phase_t phase;
  phase_t phase_next;

  always_comb begin
    phase_next  = phase;
    cls.keep    = 1'b0;
    cls.newline = 1'b0;
    unique case (phase)
      PH_ESC: begin
        phase_next = (byte_in == ByteCsiOpen) ? PH_CSI : PH_PLAIN;
      end
      PH_CSI: begin
        if (byte_in >= ByteFinalLo && byte_in <= ByteFinalHi) begin
          phase_next = PH_PLAIN;
        end
      end
      default: begin
        phase_next = PH_PLAIN;
        if (byte_in == ByteEsc) begin
          phase_next = PH_ESC;
        end else if (byte_in == ByteNewline) begin
          cls.newline = 1'b1;
        end else if (byte_in >= ByteCtrlTop || byte_in == ByteTab) begin
          cls.keep = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase <= PH_PLAIN;
    end else if (step) begin
      phase <= phase_next;
    end
  end

endmodule

[design/asla_row.sv]
module asla_row
  import asla_pkg::*;
#(
  parameter int LINE_WIDTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        clear,
  input  byte_class_t cls,
  input  logic [7:0]  byte_in,
  output logic        res_valid,
  output result_t     res
);

  localparam int LenW = $clog2(LINE_WIDTH);
  localparam logic [LenW-1:0] LenLast = LenW'(LINE_WIDTH - 1);

  logic [LenW-1:0] row_length;
  logic [LenW-1:0] row_length_next;
  logic [31:0]     next_row_seq;
  logic [31:0]     next_row_seq_next;
  logic [LenW+7:0] len_ext;
  logic            wrap;

  assign len_ext = {8'b0, row_length};
  assign wrap    = (row_length == LenLast);

  always_comb begin
    res_valid         = 1'b0;
    res               = '0;
    res.row_seq       = next_row_seq;
    row_length_next   = row_length;
    next_row_seq_next = next_row_seq;
    if (cls.keep) begin
      res_valid      = 1'b1;
      res.has_char   = 1'b1;
      res.char_value = byte_in;
      res.column     = len_ext[7:0];
      res.row_end    = wrap;
      if (wrap) begin
        row_length_next   = '0;
        next_row_seq_next = next_row_seq + 32'd1;
      end else begin
        row_length_next = row_length + LenW'(1);
      end
    end else if (cls.newline && row_length != '0) begin
      res_valid         = 1'b1;
      res.row_end       = 1'b1;
      row_length_next   = '0;
      next_row_seq_next = next_row_seq + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_length   <= '0;
      next_row_seq <= SeqStart;
    end else if (step) begin
      row_length   <= row_length_next;
      next_row_seq <= next_row_seq_next;
    end
  end

endmodule

[design/ansi_strip_line_assembler.sv]
// ANSI escape stripper and line assembler.
//
// Input channel (in_valid/in_ready, action, byte_value) carries one console
// byte per transfer, or a clear request when action is 1. Output channel
// (out_valid/out_ready) carries zero or one result per input transfer: a kept
// byte with its column and row sequence number, or a newline-only row close.
// Escape sequences (ESC x, ESC [ ... final) and control bytes other than tab
// are dropped; empty rows produce nothing. Rows wrap at LINE_WIDTH bytes.
//
// A byte transferred into the input register is decoded from it there, and its
// result is loaded into the output register when the input register drains.
// Throughput: one byte per cycle unless a stall holds the input register; the
// escape phase, row length and row sequence update as the input register drains.
// When the receiver stalls with a result held, the input register keeps its
// byte only if that byte also produces a result; otherwise it drains and
// intake continues. Reset clears both pipeline valids, the escape phase, the
// row length, and sets the row sequence to 1, same as a clear transfer.
module ansi_strip_line_assembler
  import asla_pkg::*;
#(
  parameter int LINE_WIDTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        has_char,
  output logic [7:0]  char_value,
  output logic [7:0]  column,
  output logic [31:0] row_seq,
  output logic        row_end
);

  // Input register
  logic       s1_valid;
  logic       s1_action;
  logic [7:0] s1_byte;

  // Output register
  result_t out_reg;

  byte_class_t cls;
  result_t     row_res;
  logic        row_res_valid;
  logic        s1_has_res;
  logic        out_free;
  logic        s1_fire;
  logic        step;
  logic        clear;

  assign s1_has_res = s1_valid && !s1_action && row_res_valid;
  assign out_free   = !out_valid || out_ready;
  // Drain the input register unless its result has nowhere to go
  assign s1_fire    = s1_valid && (!s1_has_res || out_free);
  assign in_ready   = !s1_valid || s1_fire;
  assign step       = s1_fire && !s1_action;
  assign clear      = s1_fire && s1_action;

  asla_filter u_filter (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .clear   (clear),
    .byte_in (s1_byte),
    .cls     (cls)
  );

  asla_row #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_row (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .clear     (clear),
    .cls       (cls),
    .byte_in   (s1_byte),
    .res_valid (row_res_valid),
    .res       (row_res)
  );

  // Input register: hold while the current byte is stuck behind the output
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_action <= action;
      s1_byte   <= byte_value;
    end
  end

  // Output register: load on a result, drop valid once the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_has_res) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_has_res) begin
      out_reg <= row_res;
    end
  end

  assign has_char   = out_reg.has_char;
  assign char_value = out_reg.char_value;
  assign column     = out_reg.column;
  assign row_seq    = out_reg.row_seq;
  assign row_end    = out_reg.row_end;

endmodule

[dv/ansi_strip_line_assembler_tb.sv]
`timescale 1ns / 1ps

module ansi_strip_line_assembler_tb;
  import asla_pkg::*;

  localparam int LineWidth = 256;
  localparam int RandomItems = 824;
  localparam int CycleLimit = 400000;
  localparam int NumPlan = 26;
  localparam int IdlePct = 32;

  // One row of the directed table: the byte to push and, where it is obvious,
  // the result typed in by hand. Rows with typed low go to the line model.
  typedef struct packed {
    logic    act;
    logic [7:0] data;
    logic    typed;
    logic    yields;
    result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = 1'b0;
  logic [7:0] byte_value = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic has_char;
  logic [7:0] char_value;
  logic [7:0] column;
  logic [31:0] row_seq;
  logic row_end;

  // Line model state: escape decoder, bytes in the open row, open row number
  phase_t esc_phase = PH_PLAIN;
  int row_len = 0;
  logic [31:0] open_seq = SeqStart;

  result_t pending_rows[$];
  int mismatches = 0;
  int cycle_count = 0;
  int random_items = 0;
  bit calm = 1'b0;
  stim_row_t plan [0:NumPlan-1];

  always #5 clk = ~clk;

  ansi_strip_line_assembler #(
    .LINE_WIDTH(LineWidth)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .byte_value(byte_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .has_char  (has_char),
    .char_value(char_value),
    .column    (column),
    .row_seq   (row_seq),
    .row_end   (row_end)
  );

  // Advance the line model by one transfer; return 1 when a result is due.
  function automatic bit predict_step(input logic act, input logic [7:0] b,
                                      output result_t r);
    r = '0;
    if (act) begin
      esc_phase = PH_PLAIN;
      row_len = 0;
      open_seq = SeqStart;
      return 1'b0;
    end
    // Consume escape bodies first: ESC x, or ESC [ ... up to a final byte
    if (esc_phase == PH_ESC) begin
      esc_phase = (b == ByteCsiOpen) ? PH_CSI : PH_PLAIN;
      return 1'b0;
    end
    if (esc_phase == PH_CSI) begin
      if (b >= ByteFinalLo && b <= ByteFinalHi) esc_phase = PH_PLAIN;
      return 1'b0;
    end
    esc_phase = PH_PLAIN;
    if (b == ByteEsc) begin
      esc_phase = PH_ESC;
      return 1'b0;
    end
    // Newline closes the row only when something is in it
    if (b == ByteNewline) begin
      if (row_len == 0) return 1'b0;
      r.row_seq = open_seq;
      r.row_end = 1'b1;
      open_seq = open_seq + 32'd1;
      row_len = 0;
      return 1'b1;
    end
    if (b < ByteCtrlTop && b != ByteTab) return 1'b0;
    r.has_char = 1'b1;
    r.char_value = b;
    r.column = row_len[7:0];
    r.row_seq = open_seq;
    row_len++;
    // Wrap: the byte that fills the row also closes it
    if (row_len >= LineWidth) begin
      r.row_end = 1'b1;
      open_seq = open_seq + 32'd1;
      row_len = 0;
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t via_model(input logic act, input logic [7:0] b);
    return '{act: act, data: b, typed: 1'b0, yields: 1'b0, want: '0};
  endfunction

  function automatic stim_row_t silent(input logic act, input logic [7:0] b);
    return '{act: act, data: b, typed: 1'b1, yields: 1'b0, want: '0};
  endfunction

  function automatic stim_row_t emits(input logic [7:0] b, input logic has,
                                      input logic [7:0] ch, input logic [7:0] col,
                                      input logic [31:0] seq, input logic closes);
    return '{act: 1'b0, data: b, typed: 1'b1, yields: 1'b1,
             want: '{has_char: has, char_value: ch, column: col,
                     row_seq: seq, row_end: closes}};
  endfunction

  // Mostly printable text, with tabs and high bytes mixed in
  function automatic logic [7:0] kept_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 8'($urandom_range(8'h20, 8'h7E));
    if (pick < 80) return ByteTab;
    return 8'($urandom_range(8'h7F, 8'hFF));
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Drive one transfer, hold it until accepted, then queue its expected row
  task automatic transfer_row(input stim_row_t rw);
    result_t guess;
    bit yields;
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= rw.act;
    byte_value <= rw.data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    yields = predict_step(rw.act, rw.data, guess);
    if (rw.typed) begin
      if (rw.yields) pending_rows.push_back(rw.want);
    end else if (yields) begin
      pending_rows.push_back(guess);
    end
    random_items++;
  endtask

  task automatic send(input logic act, input logic [7:0] b);
    transfer_row(via_model(act, b));
  endtask

  // Well-formed CSI: ESC [ params final
  task automatic send_csi();
    send(1'b0, ByteEsc);
    send(1'b0, ByteCsiOpen);
    repeat ($urandom_range(0, 3)) send(1'b0, 8'($urandom_range(8'h30, 8'h3F)));
    send(1'b0, 8'($urandom_range(8'h40, 8'h7E)));
  endtask

  // Push a given number of kept bytes, optionally with escapes and CRs between
  task automatic send_text(input int kept, input bit with_escapes);
    int n;
    int pick;
    n = 0;
    while (n < kept) begin
      pick = $urandom_range(0, 99);
      if (with_escapes && pick < 8) begin
        send_csi();
      end else if (with_escapes && pick < 12) begin
        send(1'b0, ByteEsc);
        send(1'b0, 8'($urandom_range(8'h20, 8'h7E)));
      end else if (with_escapes && pick < 15) begin
        send(1'b0, 8'h0D);
      end else begin
        send(1'b0, kept_byte());
        n++;
      end
    end
  endtask

  // Receiver: stall at random, except in the calm window
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Compare every accepted result with the oldest expected row
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_rows.size() == 0) begin
        flag_mismatch($sformatf("unexpected result char=%h col=%0d seq=%0d end=%b",
                                char_value, column, row_seq, row_end));
      end else begin
        want = pending_rows.pop_front();
        if (has_char !== want.has_char)
          flag_mismatch($sformatf("has_char %b, want %b", has_char, want.has_char));
        if (char_value !== want.char_value)
          flag_mismatch($sformatf("char_value %h, want %h", char_value, want.char_value));
        if (column !== want.column)
          flag_mismatch($sformatf("column %0d, want %0d", column, want.column));
        if (row_seq !== want.row_seq)
          flag_mismatch($sformatf("row_seq %0d, want %0d", row_seq, want.row_seq));
        if (row_end !== want.row_end)
          flag_mismatch($sformatf("row_end %b, want %b", row_end, want.row_end));
      end
    end
  end

  initial begin
    int seg;
    int kind;

    plan = '{
      silent(1'b0, ByteNewline),                          // newline on empty row
      emits(8'h41, 1'b1, 8'h41, 8'd0, 32'd1, 1'b0),
      emits(ByteTab, 1'b1, ByteTab, 8'd1, 32'd1, 1'b0),
      silent(1'b0, 8'h0D),                                // CR is dropped
      silent(1'b0, 8'h00),
      silent(1'b0, 8'h1F),
      emits(8'hFF, 1'b1, 8'hFF, 8'd2, 32'd1, 1'b0),
      emits(8'h7F, 1'b1, 8'h7F, 8'd3, 32'd1, 1'b0),
      emits(8'h20, 1'b1, 8'h20, 8'd4, 32'd1, 1'b0),
      via_model(1'b0, ByteEsc),                           // two-byte escape
      via_model(1'b0, 8'h78),
      via_model(1'b0, ByteEsc),                           // CSI with junk inside
      via_model(1'b0, ByteCsiOpen),
      via_model(1'b0, 8'h33),
      via_model(1'b0, ByteNewline),
      via_model(1'b0, 8'h7F),
      via_model(1'b0, ByteFinalHi),
      via_model(1'b0, ByteEsc),                           // CSI ended by lowest final
      via_model(1'b0, ByteCsiOpen),
      via_model(1'b0, ByteFinalLo),
      emits(ByteNewline, 1'b0, 8'h00, 8'd0, 32'd1, 1'b1),
      silent(1'b0, ByteNewline),
      via_model(1'b0, 8'h7E),
      via_model(1'b0, ByteEsc),                           // clear with escape pending
      silent(1'b1, 8'hFF),
      emits(8'h42, 1'b1, 8'h42, 8'd0, 32'd1, 1'b0)
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NumPlan; i++) transfer_row(plan[i]);

    // Random part: mostly well-formed lines, plus noise, broken escapes, clears
    random_items = 0;
    seg = 0;
    while (random_items < RandomItems) begin
      calm = (random_items >= 300 && random_items < 450);
      kind = $urandom_range(0, 99);
      if (seg == 0) begin
        // start from an empty row: exactly one full row, then a newline that
        // finds it already wrapped
        send(1'b1, 8'h00);
        send_text(LineWidth, 1'b0);
        send(1'b0, ByteNewline);
      end else if (kind < 4 && random_items < RandomItems - 320) begin
        send_text($urandom_range(LineWidth - 6, LineWidth + 44), 1'b1);
        send(1'b0, ByteNewline);
      end else if (kind < 60) begin
        send_text($urandom_range(1, 40), 1'b1);
        if ($urandom_range(0, 3) == 0) send(1'b0, 8'h0D);
        if ($urandom_range(0, 9) != 0) send(1'b0, ByteNewline);
      end else if (kind < 78) begin
        repeat ($urandom_range(1, 12))
          send($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
      end else if (kind < 90) begin
        // CSI left open; whatever follows is swallowed until a final byte
        send(1'b0, ByteEsc);
        send(1'b0, ByteCsiOpen);
        repeat ($urandom_range(1, 6)) send(1'b0, 8'($urandom_range(0, 8'h3F)));
      end else begin
        if ($urandom_range(0, 1)) send_text($urandom_range(1, 10), 1'b1);
        if ($urandom_range(0, 1)) begin
          send(1'b0, ByteEsc);
          if ($urandom_range(0, 1)) send(1'b0, ByteCsiOpen);
        end
        send(1'b1, 8'($urandom_range(0, 255)));
      end
      seg++;
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    // let any stray result show up
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/asla_pkg.sv
design/asla_filter.sv
design/asla_row.sv
design/ansi_strip_line_assembler.sv
dv/ansi_strip_line_assembler_tb.sv
